// ===== sv/phe_pkg.sv =====
// phe_pkg: constants, command codes and shared types of the pixel histogram engine
// no dependencies
package phe_pkg;

	localparam int NUM_BINS   = 256;
	localparam int COUNT_BITS = 20;
	localparam int IDX_W      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int VALUE_W    = 8;
	localparam int OUT_W      = 20;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [1:0] CMD_ACC   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef logic [IDX_W-1:0]      bin_idx_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	// write-back from the update stage into the bin store
	typedef struct packed {
		logic     en;
		bin_idx_t idx;
		count_t   data;
	} bin_wr_t;

endpackage

// ===== sv/pixel_histogram_engine.sv =====
// Histogram of 8-bit grey pixels over NUM_BINS bins of COUNT_BITS each. Every word in
// (accumulate, read, clear or the unused fourth code) gives one word out carrying the bin
// count and the largest count since the last clear. One word is taken per clock while the
// output is not stalled. The bin memory read is registered with the update stage inputs
// when a word is accepted; the output registers take its result as the stage moves on.
// A stalled output holds its word and stalls the input once the update stage is also full.
// Back-to-back hits on one bin are forwarded from the last write. Clear
// clears per-bin valid flags instead of writing the bins, so there is no clearing pass
// after reset. Counts saturate at their maximum. Depends on phe_pkg and phe_bin_store.
module pixel_histogram_engine import phe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [VALUE_W-1:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [OUT_W-1:0]   bin_count,
	output logic [OUT_W-1:0]   max_count
);

	logic         advance;
	logic         accept;
	logic         in_range;
	bin_idx_t     in_idx;
	logic [31:0]  value_w;

	logic         valid_s1;
	logic [1:0]   cmd_s1;
	bin_idx_t     idx_s1;
	logic         in_range_s1;

	count_t       old_count;
	count_t       new_count;
	count_t       bin_res;
	count_t       max_next;
	logic         clr;
	bin_wr_t      wr;

	count_t       max_q;
	logic         out_valid_q;
	logic [31:0]  bin_wide;
	logic [31:0]  max_wide;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign value_w  = 32'(value);
	assign in_range = value_w < 32'(NUM_BINS);
	assign in_idx   = value_w[IDX_W-1:0];

	phe_bin_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (accept),
		.rd_idx     (in_idx),
		.lookup_idx (idx_s1),
		.wr         (wr),
		.clr        (clr),
		.old_count  (old_count)
	);

	// an empty update stage takes a word even while the output is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= cmd;
			idx_s1      <= in_idx;
			in_range_s1 <= in_range;
		end
	end

	assign new_count = (old_count == COUNT_MAX) ? old_count : old_count + count_t'(1);

	always_comb begin
		wr.en    = 1'b0;
		wr.idx   = idx_s1;
		wr.data  = new_count;
		clr      = 1'b0;
		bin_res  = '0;
		max_next = max_q;
		unique case (cmd_s1)
			CMD_ACC: begin
				if (in_range_s1) begin
					wr.en   = 1'b1;
					bin_res = new_count;
					if (new_count > max_q) begin
						max_next = new_count;
					end
				end
			end
			CMD_READ: begin
				if (in_range_s1) begin
					bin_res = old_count;
				end
			end
			CMD_CLEAR: begin
				clr      = 1'b1;
				max_next = '0;
			end
			default: begin
				bin_res = '0;
			end
		endcase
		// nothing commits unless the stage holds a word and moves on
		if (!(valid_s1 && advance)) begin
			wr.en = 1'b0;
			clr   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				max_q <= max_next;
			end
		end
	end

	assign bin_wide = 32'(bin_res);
	assign max_wide = 32'(max_next);

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			bin_count <= bin_wide[OUT_W-1:0];
			max_count <= max_wide[OUT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/phe_bin_store.sv =====
// phe_bin_store: bin count memory with registered read, per-bin valid flags and write forwarding
// depends on phe_pkg
module phe_bin_store import phe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     rd_en,
	input  bin_idx_t rd_idx,
	input  bin_idx_t lookup_idx,
	input  bin_wr_t  wr,
	input  logic     clr,
	output count_t   old_count
);

	count_t               mem [NUM_BINS];
	count_t               rd_data_q;
	logic [NUM_BINS-1:0]  bin_valid_q;
	logic                 fwd_en_q;
	bin_idx_t             fwd_idx_q;
	count_t               fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	// a bin never written since the last clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_valid_q <= '0;
			fwd_en_q    <= 1'b0;
		end else if (clr) begin
			bin_valid_q <= '0;
			fwd_en_q    <= 1'b0;
		end else if (wr.en) begin
			bin_valid_q[wr.idx] <= 1'b1;
			fwd_en_q            <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			fwd_idx_q  <= wr.idx;
			fwd_data_q <= wr.data;
		end
	end

	// the read that coincides with a write sees stale data, so take the latest write
	always_comb begin
		if (fwd_en_q && (fwd_idx_q == lookup_idx)) begin
			old_count = fwd_data_q;
		end else if (bin_valid_q[lookup_idx]) begin
			old_count = rd_data_q;
		end else begin
			old_count = '0;
		end
	end

endmodule

// ===== dv/testbench.sv =====
// testbench for pixel_histogram_engine: directed, full-rate and random traffic with idling
// on both sides, every result checked against an in-line histogram predictor
// depends on phe_pkg and the engine rtl
module testbench;
	import phe_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// the fourth command code does nothing but report the current maximum
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RUN_LEN = 64;

	typedef struct {
		logic [OUT_W-1:0] bin;
		logic [OUT_W-1:0] peak;
	} hist_word_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         cmd;
	logic [VALUE_W-1:0] value;
	logic               out_valid;
	logic               out_stall;
	logic [OUT_W-1:0]   bin_count;
	logic [OUT_W-1:0]   max_count;

	count_t     bin_tally [NUM_BINS];
	count_t     peak_tally;
	hist_word_t awaited_words [$];
	int         mismatch_total = 0;
	int         stall_left = 0;
	bit         idle_on = 1'b1;

	pixel_histogram_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.bin_count (bin_count),
		.max_count (max_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic clear_histogram();
		foreach (bin_tally[i]) bin_tally[i] = '0;
		peak_tally = '0;
	endtask

	// updates the histogram for one accepted word and queues the word it should give
	task automatic predict_histogram(input logic [1:0] c, input logic [VALUE_W-1:0] v);
		hist_word_t w;
		count_t     n;
		n = '0;
		case (c)
			CMD_ACC: begin
				if (v < NUM_BINS) begin
					n = bin_tally[v];
					if (n != COUNT_MAX)
						n = n + count_t'(1);
					bin_tally[v] = n;
					if (n > peak_tally)
						peak_tally = n;
				end
			end
			CMD_READ: begin
				if (v < NUM_BINS)
					n = bin_tally[v];
			end
			CMD_CLEAR: clear_histogram();
			default: n = '0;
		endcase
		w.bin = n[OUT_W-1:0];
		w.peak = peak_tally[OUT_W-1:0];
		awaited_words.push_back(w);
	endtask

	task automatic report_mismatch(input string what, input logic [OUT_W-1:0] seen,
			input logic [OUT_W-1:0] wanted);
		$display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, seen, wanted);
		mismatch_total++;
	endtask

	// called just after a rising edge; returns just after the edge that takes the word
	task automatic send_word(input logic [1:0] c, input logic [VALUE_W-1:0] v);
		int gap;
		gap = idle_on ? $urandom_range(10, 0) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_histogram(c, v);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (awaited_words.size() != 0) @(posedge clk);
	endtask

	// receive side: checks each word taken and draws a stall for the next one
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_words.size() == 0) begin
					report_mismatch("unexpected word, bin_count", bin_count, '0);
				end else begin
					hist_word_t w;
					w = awaited_words.pop_front();
					if (bin_count !== w.bin)
						report_mismatch("bin_count", bin_count, w.bin);
					if (max_count !== w.peak)
						report_mismatch("max_count", max_count, w.peak);
				end
				stall_left = idle_on ? $urandom_range(10, 0) : 0;
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_stall <= (stall_left > 0);
		end
	end

	task automatic test_directed();
		send_word(CMD_READ, 8'd0);
		send_word(CMD_READ, 8'd255);
		send_word(CMD_ACC, 8'd0);
		send_word(CMD_ACC, 8'd0);
		send_word(CMD_ACC, 8'd255);
		send_word(CMD_ACC, 8'd255);
		send_word(CMD_ACC, 8'd255);
		send_word(CMD_READ, 8'd0);
		send_word(CMD_READ, 8'd255);
		send_word(CMD_UNUSED, 8'd0);
		send_word(CMD_UNUSED, 8'd255);
		send_word(CMD_ACC, 8'hAA);
		send_word(CMD_ACC, 8'h55);
		send_word(CMD_READ, 8'hAA);
		send_word(CMD_CLEAR, 8'd0);
		send_word(CMD_READ, 8'd255);
		send_word(CMD_ACC, 8'd255);
		send_word(CMD_CLEAR, 8'hFF);
		send_word(CMD_READ, 8'd0);
		send_word(CMD_UNUSED, 8'hAA);
	endtask

	// let every result come home mid-stream, then look at the same bin again
	task automatic test_pause_drain();
		repeat (3) send_word(CMD_ACC, 8'd7);
		wait_drained();
		send_word(CMD_READ, 8'd7);
		send_word(CMD_ACC, 8'd7);
		wait_drained();
		send_word(CMD_CLEAR, 8'd0);
	endtask

	// one bin hit at the full rate with no idling, so each update leans on the last write
	task automatic test_full_rate_run();
		idle_on = 1'b0;
		send_word(CMD_CLEAR, 8'd0);
		for (int i = 0; i < RUN_LEN; i++)
			send_word(CMD_ACC, 8'h5A);
		send_word(CMD_READ, 8'h5A);
		send_word(CMD_ACC, 8'hA5);
		send_word(CMD_UNUSED, 8'h5A);
		idle_on = 1'b1;
	endtask

	// mostly accumulates with a few hot bins, so back-to-back hits on one bin are common
	task automatic test_random_traffic();
		logic [VALUE_W-1:0] hot [4];
		logic [1:0]         c;
		logic [VALUE_W-1:0] v;
		int                 roll;
		foreach (hot[i]) hot[i] = VALUE_W'($urandom_range(255, 0));
		for (int i = 0; i < 2000; i++) begin
			if (i % 250 == 0)
				idle_on = ($urandom_range(3, 0) != 0);
			if (i == 1000)
				wait_drained();
			roll = $urandom_range(199, 0);
			if (roll < 140)
				c = CMD_ACC;
			else if (roll < 185)
				c = CMD_READ;
			else if (roll < 195)
				c = CMD_UNUSED;
			else
				c = CMD_CLEAR;
			if ($urandom_range(1, 0) != 0)
				v = hot[$urandom_range(3, 0)];
			else
				v = VALUE_W'($urandom_range(255, 0));
			send_word(c, v);
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_ACC;
		value = '0;
		clear_histogram();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pause_drain();
		test_full_rate_run();
		test_random_traffic();
		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatch_total == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/phe_pkg.sv
sv/phe_bin_store.sv
sv/pixel_histogram_engine.sv
dv/testbench.sv
